>>> sv/qpsk_symbol_rate_setup_unit_assert.svh
// ----------------------------------------------------------------------------
// qpsk symbol rate setup assertion macros
// clocked, reset-qualified property wrappers for the setup unit
// ----------------------------------------------------------------------------
`ifndef QPSK_SYMBOL_RATE_SETUP_UNIT_ASSERT_SVH
`define QPSK_SYMBOL_RATE_SETUP_UNIT_ASSERT_SVH

// same-cycle implication
`define QSRS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QSRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/qsrs_pkg.sv
// ----------------------------------------------------------------------------
// qsrs_pkg
// shared widths, constants, command types and word formatting functions
// ----------------------------------------------------------------------------
`default_nettype none

package qsrs_pkg;

    localparam int ClkW   = 27;
    localparam int RateW  = 26;
    localparam int InvW   = 2;
    localparam int FecW   = 4;
    localparam int DecW   = 2;
    localparam int RatioW = 24;
    localparam int ThrW   = 29;
    localparam int DvdW   = 48;
    localparam int ProdW  = 58;
    localparam int CntW   = 6;

    localparam logic [ClkW-1:0] ClkReset = 27'd96000000;
    localparam logic [31:0]     Recip3   = 32'hAAAAAAAB;
    localparam int              Recip3Sh = 33;
    localparam logic [CntW-1:0] DivLast  = 6'(DvdW - 1);

    localparam logic [InvW-1:0] InvOff = 2'd0;
    localparam logic [InvW-1:0] InvOn  = 2'd1;

    localparam logic [7:0] ViterbiOn  = 8'h60;
    localparam logic [7:0] ViterbiOff = 8'h20;
    localparam logic [7:0] ViterbiAut = 8'h00;
    localparam logic [7:0] FilterBase = 8'h20;
    localparam logic [7:0] AgcBase    = 8'h50;
    localparam logic [7:0] PunctAuto  = 8'hFF;
    localparam logic [7:0] PunctNone  = 8'h00;

    localparam logic [FecW-1:0] FecNone    = 4'd0;
    localparam logic [FecW-1:0] FecMaxRate = 4'd8;
    localparam logic [FecW-1:0] FecAuto    = 4'd9;

    localparam logic [DecW-1:0] DecDiv1 = 2'd0;
    localparam logic [DecW-1:0] DecDiv2 = 2'd1;
    localparam logic [DecW-1:0] DecDiv4 = 2'd2;
    localparam logic [DecW-1:0] DecDiv6 = 2'd3;

    typedef struct packed {
        logic load;
        logic dec_step;
        logic wc_step;
        logic cls_step;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_status;

    function automatic logic [7:0] viterbi_word(input logic [InvW-1:0] inv);
        logic [7:0] w;
        if (inv == InvOn) begin
            w = ViterbiOn;
        end else if (inv == InvOff) begin
            w = ViterbiOff;
        end else begin
            w = ViterbiAut;
        end
        return w;
    endfunction

    function automatic logic [7:0] puncture_mask(input logic [FecW-1:0] fec);
        logic [7:0] m;
        if (fec == FecNone) begin
            m = PunctNone;
        end else if (fec <= FecMaxRate) begin
            m = 8'b1 << (FecMaxRate - fec);
        end else if (fec == FecAuto) begin
            m = PunctAuto;
        end else begin
            m = PunctNone;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/qsrs_ctrl.sv
// ----------------------------------------------------------------------------
// qsrs_ctrl
// sequencer: decimation, working clock, band select, serial divide, output
// ----------------------------------------------------------------------------
`default_nettype none

module qsrs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire qsrs_pkg::t_status i_status,
    output qsrs_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_WC   = 3'd2;
    localparam logic [2:0] S_CLS  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.dec_step = 1'b1;
                n_state        = S_WC;
            end
            S_WC: begin
                o_cmd.wc_step = 1'b1;
                n_state       = S_CLS;
            end
            S_CLS: begin
                o_cmd.cls_step = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> sv/qsrs_dp.sv
// ----------------------------------------------------------------------------
// qsrs_dp
// datapath: thresholds, working clock, filter code and restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module qsrs_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire qsrs_pkg::t_cmd               i_cmd,
    output qsrs_pkg::t_status                 o_status,
    input  wire logic                         i_cfg_we,
    input  wire logic [qsrs_pkg::ClkW-1:0]    i_cfg_data,
    input  wire logic [qsrs_pkg::RateW-1:0]   i_symbol_rate,
    input  wire logic [qsrs_pkg::InvW-1:0]    i_inversion_mode,
    input  wire logic [qsrs_pkg::FecW-1:0]    i_fec_code,
    output logic [qsrs_pkg::DecW-1:0]         o_decimation,
    output logic [qsrs_pkg::RatioW-1:0]       o_clock_ratio,
    output logic [7:0]                        o_viterbi_word,
    output logic [7:0]                        o_filter_word,
    output logic [7:0]                        o_puncture_mask,
    output logic [7:0]                        o_agc_word,
    output logic                              o_rate_unsupported,
    output logic                              o_parameter_error
);

    localparam int ClkW   = qsrs_pkg::ClkW;
    localparam int RateW  = qsrs_pkg::RateW;
    localparam int ThrW   = qsrs_pkg::ThrW;
    localparam int DvdW   = qsrs_pkg::DvdW;
    localparam int ProdW  = qsrs_pkg::ProdW;
    localparam int CntW   = qsrs_pkg::CntW;
    localparam int DecW   = qsrs_pkg::DecW;
    localparam int RatioW = qsrs_pkg::RatioW;

    logic [ClkW-1:0]            r_clk_hz;
    logic [RateW-1:0]           r_sr;
    logic [qsrs_pkg::InvW-1:0]  r_inv;
    logic [qsrs_pkg::FecW-1:0]  r_fec;
    logic [DecW-1:0]            r_dec, n_dec;
    logic [ProdW-1:0]           r_prod;
    logic [ClkW-1:0]            r_wc, n_wc;
    logic [2:0]                 r_filt, n_filt;
    logic                       r_unsup, n_unsup;
    logic [RateW-1:0]           r_rem;
    logic [DvdW-1:0]            r_quo, n_quo_init;
    logic [CntW-1:0]            r_cnt;

    logic [ThrW-1:0]  sr_x, clk3, wc3, wc_x;
    logic [RateW:0]   trial, diff;
    logic             ge;

    assign sr_x = ThrW'(r_sr);
    assign clk3 = ThrW'(r_clk_hz) + {ThrW'(r_clk_hz) << 1};
    assign wc_x = ThrW'(r_wc);
    assign wc3  = wc_x + (wc_x << 1);

    // decimation from system clock bands
    always_comb begin
        priority if (sr_x > (clk3 >> 4)) begin
            n_dec = qsrs_pkg::DecDiv1;
        end else if (sr_x > (clk3 >> 5)) begin
            n_dec = qsrs_pkg::DecDiv2;
        end else if (sr_x > (clk3 >> 6)) begin
            n_dec = qsrs_pkg::DecDiv4;
        end else begin
            n_dec = qsrs_pkg::DecDiv6;
        end
    end

    // working clock, divide by six via reciprocal of three on clk/2
    always_comb begin
        unique case (r_dec)
            qsrs_pkg::DecDiv1: n_wc = r_clk_hz;
            qsrs_pkg::DecDiv2: n_wc = r_clk_hz >> 1;
            qsrs_pkg::DecDiv4: n_wc = r_clk_hz >> 2;
            default:           n_wc = ClkW'(r_prod >> qsrs_pkg::Recip3Sh);
        endcase
    end

    // anti-alias code and band scale
    always_comb begin
        n_unsup = 1'b0;
        priority if (sr_x < (wc3 >> 6)) begin
            n_unsup = 1'b1;
            n_filt  = 3'd0;
        end else if (sr_x <= (wc_x >> 4)) begin
            n_filt = 3'd7;
        end else if (sr_x <= (wc3 >> 5)) begin
            n_filt = 3'd6;
        end else if (sr_x <= (wc_x >> 3)) begin
            n_filt = 3'd5;
        end else if (sr_x <= (wc3 >> 4)) begin
            n_filt = 3'd4;
        end else if (sr_x <= (wc_x >> 2)) begin
            n_filt = 3'd3;
        end else if (sr_x <= (wc3 >> 3)) begin
            n_filt = 3'd2;
        end else if (sr_x <= (wc_x >> 1)) begin
            n_filt = 3'd1;
        end else begin
            n_filt = 3'd0;
        end
    end

    always_comb begin
        priority if (sr_x <= (wc3 >> 5)) begin
            n_quo_init = DvdW'(r_wc) << 19;
        end else if (sr_x <= (wc3 >> 4)) begin
            n_quo_init = DvdW'(r_wc) << 20;
        end else begin
            n_quo_init = DvdW'(r_wc) << 21;
        end
    end

    // restoring divide, one quotient bit per cycle
    assign trial = {r_rem, r_quo[DvdW-1]};
    assign ge    = (trial >= {1'b0, r_sr});
    assign diff  = trial - {1'b0, r_sr};

    assign o_status.div_last = (r_cnt == qsrs_pkg::DivLast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= qsrs_pkg::ClkReset;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_data;
            end
            if (i_cmd.cls_step) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sr  <= i_symbol_rate;
            r_inv <= i_inversion_mode;
            r_fec <= i_fec_code;
        end
        if (i_cmd.dec_step) begin
            r_dec  <= n_dec;
            r_prod <= ProdW'(r_clk_hz[ClkW-1:1]) * ProdW'(qsrs_pkg::Recip3);
        end
        if (i_cmd.wc_step) begin
            r_wc <= n_wc;
        end
        if (i_cmd.cls_step) begin
            r_filt  <= n_filt;
            r_unsup <= n_unsup;
            r_quo   <= n_quo_init;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[RateW-1:0] : trial[RateW-1:0];
            r_quo <= {r_quo[DvdW-2:0], ge};
        end
        if (i_cmd.out_load) begin
            o_decimation       <= r_dec;
            o_clock_ratio      <= r_quo[RatioW-1:0];
            o_viterbi_word     <= qsrs_pkg::viterbi_word(r_inv);
            o_filter_word      <= qsrs_pkg::FilterBase | {5'b0, r_filt};
            o_puncture_mask    <= qsrs_pkg::puncture_mask(r_fec);
            o_agc_word         <= qsrs_pkg::AgcBase | {6'b0, r_dec};
            o_rate_unsupported <= r_unsup;
            o_parameter_error  <= (r_fec > qsrs_pkg::FecAuto);
        end
    end

endmodule

`default_nettype wire

>>> sv/qpsk_symbol_rate_setup_unit.sv
// sequence: load, decimation, working clock, band select, then the 48-step
// serial divider and output load; no new word is taken until the output is loaded
// a result waiting at the output does not block the next input word
// reset: synchronous active low; clears the sequencer and output valid, and
// loads the system clock register with 96000000
// ----------------------------------------------------------------------------
// qpsk_symbol_rate_setup_unit
// demodulator set-up words from symbol rate, inversion mode and fec code
// ----------------------------------------------------------------------------
`default_nettype none

`include "qpsk_symbol_rate_setup_unit_assert.svh"

module qpsk_symbol_rate_setup_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [qsrs_pkg::ClkW-1:0]    i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [qsrs_pkg::RateW-1:0]   i_symbol_rate,
    input  wire logic [qsrs_pkg::InvW-1:0]    i_inversion_mode,
    input  wire logic [qsrs_pkg::FecW-1:0]    i_fec_code,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [qsrs_pkg::DecW-1:0]         o_decimation,
    output logic [qsrs_pkg::RatioW-1:0]       o_clock_ratio,
    output logic [7:0]                        o_viterbi_word,
    output logic [7:0]                        o_filter_word,
    output logic [7:0]                        o_puncture_mask,
    output logic [7:0]                        o_agc_word,
    output logic                              o_rate_unsupported,
    output logic                              o_parameter_error
);

    qsrs_pkg::t_cmd    cmd;
    qsrs_pkg::t_status status;

    qsrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    qsrs_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_symbol_rate      (i_symbol_rate),
        .i_inversion_mode   (i_inversion_mode),
        .i_fec_code         (i_fec_code),
        .o_decimation       (o_decimation),
        .o_clock_ratio      (o_clock_ratio),
        .o_viterbi_word     (o_viterbi_word),
        .o_filter_word      (o_filter_word),
        .o_puncture_mask    (o_puncture_mask),
        .o_agc_word         (o_agc_word),
        .o_rate_unsupported (o_rate_unsupported),
        .o_parameter_error  (o_parameter_error)
    );

    `QSRS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")
    `QSRS_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !(o_out_valid && i_out_stall), "stalled word overwritten")
    `QSRS_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one command")
    `QSRS_ASSERT_NEXT(a_load_starts, cmd.load, cmd.dec_step, "decimation step missing after load")

endmodule

`default_nettype wire

>>> tb/qpsk_symbol_rate_setup_unit_tb.sv
// ----------------------------------------------------------------------------
// qpsk_symbol_rate_setup_unit_tb
// checks the demodulator set-up words against an in-bench predictor: directed
// band edges, zero rate and every fec code, then random tuning requests across
// several system clock settings with random idling on both sides and one long
// output hold-off that backs the unit up
// ----------------------------------------------------------------------------
`default_nettype none

module qpsk_symbol_rate_setup_unit_tb;

    localparam int ClkW   = qsrs_pkg::ClkW;
    localparam int RateW  = qsrs_pkg::RateW;
    localparam int InvW   = qsrs_pkg::InvW;
    localparam int FecW   = qsrs_pkg::FecW;
    localparam int DecW   = qsrs_pkg::DecW;
    localparam int RatioW = qsrs_pkg::RatioW;

    localparam int unsigned RateMax    = 45000000;
    localparam int          PhaseCount = 8;
    localparam int          PhaseReqs  = 180;
    localparam int          DirCount   = 22;
    localparam int          DrainWait  = 60;

    typedef struct packed {
        logic [RateW-1:0] rate;
        logic [InvW-1:0]  inv;
        logic [FecW-1:0]  fec;
    } t_tune_req;

    typedef struct packed {
        logic [DecW-1:0]   dec;
        logic [RatioW-1:0] ratio;
        logic [7:0]        vit;
        logic [7:0]        filt;
        logic [7:0]        punct;
        logic [7:0]        agc;
        logic              unsup;
        logic              perr;
    } t_setup_words;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_cfg_we         = 1'b0;
    logic [ClkW-1:0]    i_cfg_data       = '0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_stall;
    logic [RateW-1:0]   i_symbol_rate    = '0;
    logic [InvW-1:0]    i_inversion_mode = '0;
    logic [FecW-1:0]    i_fec_code       = '0;
    logic               o_out_valid;
    logic               i_out_stall      = 1'b0;
    logic [DecW-1:0]    o_decimation;
    logic [RatioW-1:0]  o_clock_ratio;
    logic [7:0]         o_viterbi_word;
    logic [7:0]         o_filter_word;
    logic [7:0]         o_puncture_mask;
    logic [7:0]         o_agc_word;
    logic               o_rate_unsupported;
    logic               o_parameter_error;

    t_tune_req    pending_reqs [$];
    t_setup_words expected_words [$];
    logic [ClkW-1:0] sys_clock = qsrs_pkg::ClkReset;
    int           err_count    = 0;
    int           n_accepted   = 0;
    int           tx_gap       = 0;
    int           rx_gap       = 0;
    int           rx_hold_left = 0;
    logic         hold_done    = 1'b0;
    logic         quiet_tail   = 1'b0;

    qpsk_symbol_rate_setup_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_symbol_rate      (i_symbol_rate),
        .i_inversion_mode   (i_inversion_mode),
        .i_fec_code         (i_fec_code),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_decimation       (o_decimation),
        .o_clock_ratio      (o_clock_ratio),
        .o_viterbi_word     (o_viterbi_word),
        .o_filter_word      (o_filter_word),
        .o_puncture_mask    (o_puncture_mask),
        .o_agc_word         (o_agc_word),
        .o_rate_unsupported (o_rate_unsupported),
        .o_parameter_error  (o_parameter_error)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_setup_words predict_setup(
        input logic [RateW-1:0] rate,
        input logic [InvW-1:0]  inv,
        input logic [FecW-1:0]  fec,
        input logic [ClkW-1:0]  clk
    );
        logic [63:0]  sr;
        logic [63:0]  c;
        logic [63:0]  wc;
        logic [63:0]  k;
        logic [63:0]  q;
        t_setup_words w;
        sr = 64'(rate);
        c  = 64'(clk);
        if (sr > c * 3 / 16) begin
            w.dec = qsrs_pkg::DecDiv1;
        end else if (sr > c * 3 / 32) begin
            w.dec = qsrs_pkg::DecDiv2;
        end else if (sr > c * 3 / 64) begin
            w.dec = qsrs_pkg::DecDiv4;
        end else begin
            w.dec = qsrs_pkg::DecDiv6;
        end
        case (w.dec)
            qsrs_pkg::DecDiv1: wc = c;
            qsrs_pkg::DecDiv2: wc = c / 2;
            qsrs_pkg::DecDiv4: wc = c / 4;
            default:           wc = c / 6;
        endcase

        if (sr <= wc * 3 / 32) begin
            k = 64'd1 << 19;
        end else if (sr <= wc * 3 / 16) begin
            k = 64'd1 << 20;
        end else begin
            k = 64'd1 << 21;
        end
        if (sr == 0) begin
            w.ratio = '1;
        end else begin
            q       = (k * wc) / sr;
            w.ratio = q[RatioW-1:0];
        end

        // anti-alias code by band of the working clock
        w.unsup = 1'b0;
        w.filt  = qsrs_pkg::FilterBase;
        if (sr < wc * 3 / 64) begin
            w.unsup = 1'b1;
        end else if (sr <= wc / 16) begin
            w.filt = qsrs_pkg::FilterBase | 8'd7;
        end else if (sr <= wc * 3 / 32) begin
            w.filt = qsrs_pkg::FilterBase | 8'd6;
        end else if (sr <= wc / 8) begin
            w.filt = qsrs_pkg::FilterBase | 8'd5;
        end else if (sr <= wc * 3 / 16) begin
            w.filt = qsrs_pkg::FilterBase | 8'd4;
        end else if (sr <= wc / 4) begin
            w.filt = qsrs_pkg::FilterBase | 8'd3;
        end else if (sr <= wc * 3 / 8) begin
            w.filt = qsrs_pkg::FilterBase | 8'd2;
        end else if (sr <= wc / 2) begin
            w.filt = qsrs_pkg::FilterBase | 8'd1;
        end

        if (inv == qsrs_pkg::InvOn) begin
            w.vit = qsrs_pkg::ViterbiOn;
        end else if (inv == qsrs_pkg::InvOff) begin
            w.vit = qsrs_pkg::ViterbiOff;
        end else begin
            w.vit = qsrs_pkg::ViterbiAut;
        end

        w.perr = 1'b0;
        if (fec == qsrs_pkg::FecNone) begin
            w.punct = qsrs_pkg::PunctNone;
        end else if (fec <= qsrs_pkg::FecMaxRate) begin
            w.punct = 8'd1 << (qsrs_pkg::FecMaxRate - fec);
        end else if (fec == qsrs_pkg::FecAuto) begin
            w.punct = qsrs_pkg::PunctAuto;
        end else begin
            w.punct = qsrs_pkg::PunctNone;
            w.perr  = 1'b1;
        end

        w.agc = qsrs_pkg::AgcBase | 8'(w.dec);
        return w;
    endfunction

    function automatic t_tune_req random_request(input logic [ClkW-1:0] clk);
        t_tune_req   r;
        logic [63:0] t;
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick < 3) begin
            t = $urandom_range(1, RateMax);
        end else if (pick < 6) begin
            // close to a band edge of the current clock
            t = (64'(clk) * $urandom_range(1, 8)) >> $urandom_range(3, 10);
            t = t + $urandom_range(0, 4);
            t = (t > 2) ? t - 2 : 64'd1;
        end else if (pick == 6) begin
            t = $urandom_range(1, 1 + clk / 2);
        end else begin
            t = $urandom_range(0, 1000);
        end
        if (t > RateMax) begin
            t = RateMax;
        end
        r.rate = t[RateW-1:0];
        r.inv  = InvW'($urandom_range(0, 3));
        r.fec  = FecW'($urandom_range(0, 15));
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_proc
        logic holding;
        if (i_rst_n) begin
            holding = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_words.push_back(predict_setup(i_symbol_rate, i_inversion_mode,
                                                       i_fec_code, sys_clock));
                void'(pending_reqs.pop_front());
                n_accepted <= n_accepted + 1;
                holding = 1'b0;
            end
            if (!holding) begin
                if (tx_gap != 0) begin
                    tx_gap     <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0 && !quiet_tail
                             && $urandom_range(0, 15) == 0) begin
                    tx_gap     <= $urandom_range(0, 10);
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    i_in_valid       <= 1'b1;
                    i_symbol_rate    <= pending_reqs[0].rate;
                    i_inversion_mode <= pending_reqs[0].inv;
                    i_fec_code       <= pending_reqs[0].fec;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off so the unit backs up
    always @(posedge i_clk) begin
        if (!hold_done && n_accepted == 60) begin
            rx_hold_left <= 500;
            hold_done    <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_proc
        t_setup_words want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected", $time);
                    err_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("decimation", 32'(want.dec), 32'(o_decimation));
                    check_field("clock_ratio", 32'(want.ratio), 32'(o_clock_ratio));
                    check_field("viterbi_word", 32'(want.vit), 32'(o_viterbi_word));
                    check_field("filter_word", 32'(want.filt), 32'(o_filter_word));
                    check_field("puncture_mask", 32'(want.punct), 32'(o_puncture_mask));
                    check_field("agc_word", 32'(want.agc), 32'(o_agc_word));
                    check_field("rate_unsupported", 32'(want.unsup),
                                32'(o_rate_unsupported));
                    check_field("parameter_error", 32'(want.perr),
                                32'(o_parameter_error));
                end
            end
            if (rx_hold_left != 0) begin
                i_out_stall <= 1'b1;
            end else if (rx_gap != 0) begin
                rx_gap      <= rx_gap - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                rx_gap      <= $urandom_range(0, 10);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : run_proc
        logic [ClkW-1:0] phase_clk [PhaseCount];
        int unsigned     dir_rates [DirCount];
        t_tune_req       req;
        int              p;
        int              i;
        phase_clk = '{27'd96000000, 27'd27000000, 27'd134217727, 27'd1, 27'd0,
                      27'd0, 27'd60000000, 27'd96000000};
        phase_clk[5] = ClkW'($urandom_range(1, 134217727));
        // band edges at 96 MHz: 18M, 9M, 4.5M; unsupported below 750k
        dir_rates = '{0, 1, 45000000, 18000000, 18000001, 9000000, 9000001,
                      4500000, 4500001, 750000, 749999, 1000000, 1500000,
                      2000000, 3000000, 27500000, 22000000, 33554432,
                      30000000, 24000000, 6000000, 12000000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < PhaseCount; p++) begin
            if (p == PhaseCount - 1) begin
                quiet_tail <= 1'b1;
            end
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_data <= phase_clk[p];
            @(posedge i_clk);
            i_cfg_we  <= 1'b0;
            sys_clock = phase_clk[p];
            @(negedge i_clk);
            if (p == 0) begin
                for (i = 0; i < DirCount; i++) begin
                    req.rate = RateW'(dir_rates[i]);
                    req.inv  = InvW'(i % 4);
                    req.fec  = FecW'(i % 16);
                    pending_reqs.push_back(req);
                end
            end
            for (i = 0; i < PhaseReqs; i++) begin
                pending_reqs.push_back(random_request(phase_clk[p]));
            end
            while (pending_reqs.size() != 0 || i_in_valid || expected_words.size() != 0) begin
                @(posedge i_clk);
            end
            repeat (DrainWait) @(posedge i_clk);
        end

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/qsrs_pkg.sv
sv/qsrs_ctrl.sv
sv/qsrs_dp.sv
sv/qpsk_symbol_rate_setup_unit.sv
tb/qpsk_symbol_rate_setup_unit_tb.sv
